// ===== rtl/core/srec_pkg.sv =====
// Shared types, phase codes and character helpers for the S1 record extractor.
// No dependencies.
package srec_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned PhaseW = 3;

  // Parser phase codes
  localparam logic [PhaseW-1:0] PhHunt    = 3'd0;
  localparam logic [PhaseW-1:0] PhGotS    = 3'd1;
  localparam logic [PhaseW-1:0] PhCount   = 3'd2;
  localparam logic [PhaseW-1:0] PhAddr    = 3'd3;
  localparam logic [PhaseW-1:0] PhData    = 3'd4;
  localparam logic [PhaseW-1:0] PhSwallow = 3'd5;

  localparam logic [CharW-1:0] ChS       = 8'h53;
  localparam logic [CharW-1:0] ChOne     = 8'h31;
  localparam logic [CharW-1:0] ChDigLo   = 8'h30;
  localparam logic [CharW-1:0] ChDigHi   = 8'h39;
  localparam logic [CharW-1:0] ChHexLo   = 8'h41;
  localparam logic [CharW-1:0] ChHexHi   = 8'h46;
  localparam logic [CharW-1:0] HexOffset = 8'h37;
  localparam logic [CharW-1:0] ChLowLo   = 8'h61;
  localparam logic [CharW-1:0] ChLowHi   = 8'h7A;
  localparam logic [CharW-1:0] CaseDelta = 8'h20;
  localparam logic [CharW-1:0] HdrBytes  = 8'd3;
  localparam logic [CharW-1:0] BadDigit  = 8'hFF;

  typedef logic [CharW-1:0] char_t;
  typedef logic [AddrW-1:0] addr_t;

  // Lowercase letters become uppercase
  function automatic char_t fold_upper(input char_t c);
    char_t r;
    r = c;
    if (c >= ChLowLo && c <= ChLowHi) r = c - CaseDelta;
    return r;
  endfunction

  // Hex digit value; anything else is all ones
  function automatic char_t digit_value(input char_t c);
    char_t r;
    r = BadDigit;
    if (c >= ChDigLo && c <= ChDigHi)      r = c - ChDigLo;
    else if (c >= ChHexLo && c <= ChHexHi) r = c - HexOffset;
    return r;
  endfunction

endpackage

// ===== rtl/core/srec_if.sv =====
// Valid/ready channel interfaces for the S1 record extractor.
// Depends on srec_pkg.
interface srec_char_if;
  logic                 valid;
  logic                 ready;
  srec_pkg::char_t      in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface srec_rec_if;
  logic                 valid;
  logic                 ready;
  srec_pkg::char_t      data_byte;
  srec_pkg::addr_t      byte_address;

  modport source (output valid, output data_byte, output byte_address, input ready);
  modport sink   (input valid, input data_byte, input byte_address, output ready);
endinterface

// ===== rtl/core/srecord_s1_data_extractor_core.sv =====
// S1 record extractor top level: character parser plus output register.
// Depends on srec_pkg and the channel interfaces in srec_if.sv.

// Takes one ASCII character per request and pulls the data bytes out of
// Motorola S1 records. Lowercase is folded to uppercase. After "S1" come two
// count digits (data bytes = count - 3, mod 256), four address digits, then
// one result per pair of data digits carrying the byte and its address; the
// address steps by one, mod 65536. Checksums and other record types are not
// checked, text outside a record is skipped. Non-hex digits count as 255 and
// fields keep the low bits of the shifted sum. A record with zero data bytes
// consumes one extra character. Throughput is one character per clock while
// the output is not stalled: the parser state updates in the cycle a character
// is taken and a result lands in a single output register, refilled in the
// same cycle it is drained; it is valid the cycle after its last digit.
module srecord_s1_data_extractor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  srec_char_if.sink  char_i,
  srec_rec_if.source rec_o
);

  // Parser state
  logic [srec_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [1:0]                  dcnt_q, dcnt_d;
  srec_pkg::addr_t             acc_q, acc_d;
  srec_pkg::char_t             remain_q, remain_d;
  srec_pkg::addr_t             addr_q, addr_d;

  // Output register
  logic            ovalid_q, ovalid_d;
  srec_pkg::char_t obyte_q;
  srec_pkg::addr_t oaddr_q;

  srec_pkg::char_t c_up;
  srec_pkg::addr_t acc_next;
  srec_pkg::char_t remain_dec;
  logic            take;
  logic            emit;

  // Accept whenever the output slot is empty or emptying this cycle
  assign char_i.ready = !ovalid_q || rec_o.ready;
  assign take         = char_i.valid && char_i.ready;

  assign c_up       = srec_pkg::fold_upper(char_i.in_char);
  assign acc_next   = {acc_q[srec_pkg::AddrW-5:0], 4'h0}
                    + {8'h00, srec_pkg::digit_value(c_up)};
  assign remain_dec = remain_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    dcnt_d   = dcnt_q;
    acc_d    = acc_q;
    remain_d = remain_q;
    addr_d   = addr_q;
    emit     = 1'b0;
    if (take) begin
      unique case (phase_q)
        srec_pkg::PhGotS: begin
          if (c_up == srec_pkg::ChOne) begin
            phase_d = srec_pkg::PhCount;
            dcnt_d  = 2'd0;
            acc_d   = '0;
          end else begin
            // S not followed by 1: this char may itself start a record
            phase_d = (c_up == srec_pkg::ChS) ? srec_pkg::PhGotS : srec_pkg::PhHunt;
          end
        end
        srec_pkg::PhCount: begin
          acc_d = acc_next;
          if (dcnt_q == 2'd1) begin
            remain_d = acc_next[7:0] - srec_pkg::HdrBytes;
            phase_d  = srec_pkg::PhAddr;
            dcnt_d   = 2'd0;
            acc_d    = '0;
          end else begin
            dcnt_d = dcnt_q + 2'd1;
          end
        end
        srec_pkg::PhAddr: begin
          acc_d = acc_next;
          if (dcnt_q == 2'd3) begin
            addr_d  = acc_next;
            // empty record: drop the next char unseen
            phase_d = (remain_q == '0) ? srec_pkg::PhSwallow : srec_pkg::PhData;
            dcnt_d  = 2'd0;
            acc_d   = '0;
          end else begin
            dcnt_d = dcnt_q + 2'd1;
          end
        end
        srec_pkg::PhData: begin
          acc_d = acc_next;
          if (dcnt_q == 2'd1) begin
            emit     = 1'b1;
            addr_d   = addr_q + 16'd1;
            remain_d = remain_dec;
            phase_d  = (remain_dec == '0) ? srec_pkg::PhHunt : srec_pkg::PhData;
            dcnt_d   = 2'd0;
            acc_d    = '0;
          end else begin
            dcnt_d = dcnt_q + 2'd1;
          end
        end
        srec_pkg::PhSwallow: begin
          phase_d = srec_pkg::PhHunt;
        end
        default: begin
          // hunting, and the unused codes
          phase_d = (c_up == srec_pkg::ChS) ? srec_pkg::PhGotS : srec_pkg::PhHunt;
        end
      endcase
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (rec_o.ready) ovalid_d = 1'b0;
    if (emit)        ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= srec_pkg::PhHunt;
      dcnt_q   <= '0;
      acc_q    <= '0;
      remain_q <= '0;
      addr_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      dcnt_q   <= dcnt_d;
      acc_q    <= acc_d;
      remain_q <= remain_d;
      addr_q   <= addr_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload: data byte is the low half of the finished accumulator
  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= acc_next[7:0];
      oaddr_q <= addr_q;
    end
  end

  assign rec_o.valid        = ovalid_q;
  assign rec_o.data_byte    = obyte_q;
  assign rec_o.byte_address = oaddr_q;

endmodule
